@@ hdl/pss_pkg.sv @@
// shared constants and control types for the prime sum search block
`timescale 1ns / 1ps

package pss_pkg;

   // fixed widths of the request and response fields
   localparam int COUNT_WIDTH = 11;
   localparam int START_WIDTH = 16;
   localparam int SUM_WIDTH   = 32;

   // defaults for the top level parameters
   localparam int VALUE_BITS_DEFAULT = 16;
   localparam int COUNT_MAX_DEFAULT  = 1024;
   localparam int SUM_BITS_DEFAULT   = 32;

   localparam int FIRST_PRIME = 2;

   // controller to datapath
   typedef struct packed {
      logic load;       // latch a new request and clear the search
      logic div_init;   // divisor back to the first prime
      logic div_start;  // set up the remainder unit for the current divisor
      logic div_step;   // one bit of the remainder
      logic div_next;   // move on to the next divisor
      logic add_prime;  // add the candidate into the sum
      logic cand_next;  // move on to the next candidate
      logic out_load;   // move the sum into the result register
   } pss_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_done;  // enough primes found
      logic cand_small;  // candidate below the first prime
      logic sq_gt;       // divisor squared exceeds the candidate
      logic div_last;    // last remainder bit being worked
      logic rem_zero;    // remainder of the last division is zero
   } pss_status_type;

endpackage

@@ hdl/pss_datapath.sv @@
// datapath: candidate, divisor and sum registers with a bit-serial remainder unit
`timescale 1ns / 1ps

module pss_datapath #(
   parameter int VALUE_BITS = pss_pkg::VALUE_BITS_DEFAULT,
   parameter int COUNT_MAX  = pss_pkg::COUNT_MAX_DEFAULT,
   parameter int SUM_BITS   = pss_pkg::SUM_BITS_DEFAULT
) (
   input  logic                               clock,
   input  pss_pkg::pss_cmd_type               cmd,
   output pss_pkg::pss_status_type            status,
   input  logic [pss_pkg::COUNT_WIDTH-1:0]    req_prime_count,
   input  logic [pss_pkg::START_WIDTH-1:0]    req_start_value,
   output logic [pss_pkg::SUM_WIDTH-1:0]      rsp_prime_sum
);

   // room for the start value plus the climb through the primes after it
   localparam int CAND_BITS  = (VALUE_BITS + 1 > 20) ? VALUE_BITS + 1 : 20;
   localparam int DIV_BITS   = (CAND_BITS + 1) / 2 + 1;
   localparam int SQ_BITS    = 2 * DIV_BITS;
   localparam int IDX_BITS   = $clog2(CAND_BITS);
   localparam int CNT_BITS   = $clog2(COUNT_MAX + 1);
   localparam int START_BITS = (VALUE_BITS < pss_pkg::START_WIDTH) ?
                               VALUE_BITS : pss_pkg::START_WIDTH;

   logic [CNT_BITS-1:0]  want_ff,  want_in;
   logic [CNT_BITS-1:0]  found_ff, found_in;
   logic [CAND_BITS-1:0] cand_ff,  cand_in;
   logic [SUM_BITS-1:0]  sum_ff,   sum_in;
   logic [DIV_BITS-1:0]  div_ff,   div_in;
   logic [SQ_BITS-1:0]   sq_ff,    sq_in;
   logic [DIV_BITS-1:0]  rem_ff,   rem_in;
   logic [CAND_BITS-1:0] dvd_ff,   dvd_in;
   logic [IDX_BITS-1:0]  idx_ff,   idx_in;
   logic [SUM_BITS-1:0]  out_ff,   out_in;

   logic [DIV_BITS:0]    trial;
   logic [DIV_BITS:0]    diff;
   logic [SUM_BITS:0]    sum_wide;

   always_comb begin
      trial    = {rem_ff, dvd_ff[CAND_BITS-1]};
      diff     = trial - {1'b0, div_ff};
      sum_wide = {1'b0, sum_ff} + (SUM_BITS + 1)'(cand_ff);

      want_in  = want_ff;
      found_in = found_ff;
      cand_in  = cand_ff;
      sum_in   = sum_ff;
      div_in   = div_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      idx_in   = idx_ff;
      out_in   = out_ff;

      if (cmd.load) begin
         if (32'(req_prime_count) > 32'(COUNT_MAX)) begin
            want_in = CNT_BITS'(COUNT_MAX);
         end else begin
            want_in = CNT_BITS'(req_prime_count);
         end
         found_in = '0;
         sum_in   = '0;
         cand_in  = CAND_BITS'(req_start_value[START_BITS-1:0]);
      end
      if (cmd.div_init) begin
         div_in = DIV_BITS'(pss_pkg::FIRST_PRIME);
         sq_in  = SQ_BITS'(pss_pkg::FIRST_PRIME * pss_pkg::FIRST_PRIME);
      end
      if (cmd.div_start) begin
         rem_in = '0;
         dvd_in = cand_ff;
         idx_in = IDX_BITS'(CAND_BITS - 1);
      end
      if (cmd.div_step) begin
         // restoring step: keep the difference unless it went negative
         if (!diff[DIV_BITS]) begin
            rem_in = diff[DIV_BITS-1:0];
         end else begin
            rem_in = trial[DIV_BITS-1:0];
         end
         dvd_in = {dvd_ff[CAND_BITS-2:0], 1'b0};
         idx_in = idx_ff - 1'b1;
      end
      if (cmd.div_next) begin
         // (d+1)^2 = d^2 + 2d + 1
         sq_in  = sq_ff + SQ_BITS'({div_ff, 1'b1});
         div_in = div_ff + 1'b1;
      end
      if (cmd.add_prime) begin
         if (sum_wide[SUM_BITS]) begin
            sum_in = '1;
         end else begin
            sum_in = sum_wide[SUM_BITS-1:0];
         end
         found_in = found_ff + 1'b1;
      end
      if (cmd.cand_next) begin
         cand_in = cand_ff + 1'b1;
      end
      if (cmd.out_load) begin
         out_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      want_ff  <= want_in;
      found_ff <= found_in;
      cand_ff  <= cand_in;
      sum_ff   <= sum_in;
      div_ff   <= div_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      idx_ff   <= idx_in;
      out_ff   <= out_in;
   end

   always_comb begin
      status.count_done = (found_ff >= want_ff);
      status.cand_small = (cand_ff < CAND_BITS'(pss_pkg::FIRST_PRIME));
      status.sq_gt      = (sq_ff > SQ_BITS'(cand_ff));
      status.div_last   = (idx_ff == '0);
      status.rem_zero   = (rem_ff == '0);
   end

   assign rsp_prime_sum = pss_pkg::SUM_WIDTH'(out_ff);

endmodule

@@ hdl/pss_control.sv @@
// controller: sequences the candidate search and the trial divisions
`timescale 1ns / 1ps

module pss_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pss_pkg::pss_cmd_type    cmd,
   input  pss_pkg::pss_status_type status
);

   typedef enum logic [2:0] {
      IDLE,
      SEARCH,
      DIV_CHECK,
      DIVIDE,
      REM_CHECK,
      ADVANCE,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = SEARCH;
            end
         end
         SEARCH: begin
            if (status.count_done) begin
               state_in = FINISH;
            end else if (status.cand_small) begin
               cmd.cand_next = 1'b1;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = DIV_CHECK;
            end
         end
         DIV_CHECK: begin
            // no divisor up to the square root: prime
            if (status.sq_gt) begin
               cmd.add_prime = 1'b1;
               state_in      = ADVANCE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = DIVIDE;
            end
         end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = REM_CHECK;
            end
         end
         REM_CHECK: begin
            if (status.rem_zero) begin
               state_in = ADVANCE;
            end else begin
               cmd.div_next = 1'b1;
               state_in     = DIV_CHECK;
            end
         end
         ADVANCE: begin
            if (status.count_done) begin
               state_in = FINISH;
            end else begin
               cmd.cand_next = 1'b1;
               state_in      = SEARCH;
            end
         end
         FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a result only appears out of the finish state
   a_rsp_from_finish : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == FINISH))
      else $error("result raised outside finish");

   // never overwrite a result that has not been taken
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result register overwritten");

   // a satisfied count ends the search at once
   a_done_finishes : assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEARCH && status.count_done) |=> state_ff == FINISH)
      else $error("search continued past the count");

   // the last remainder bit always leads to the remainder test
   a_div_ends : assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIVIDE && status.div_last) |=> state_ff == REM_CHECK)
      else $error("division did not end");

endmodule

@@ hdl/prime_sum_search.sv @@
// top level of the prime sum search block
`timescale 1ns / 1ps

// Takes a beat of (prime_count, start_value) and returns one beat holding the
// sum of the first prime_count primes at or above start_value, saturating at
// the all-ones value of SUM_BITS; a count of zero gives zero and counts above
// COUNT_MAX are clamped. One request is worked at a time. Each candidate is
// tried with divisors d from 2 upward while d*d <= candidate, until one divides
// it (a candidate below the first prime is skipped untested); each trial is
// worked by the bit-serial remainder unit that does one quotient bit per cycle.
// req_ready is high only between requests; a finished result waits in its own
// register, so the next request is accepted while it is still pending.

module prime_sum_search #(
   parameter int VALUE_BITS = pss_pkg::VALUE_BITS_DEFAULT,
   parameter int COUNT_MAX  = pss_pkg::COUNT_MAX_DEFAULT,
   parameter int SUM_BITS   = pss_pkg::SUM_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pss_pkg::COUNT_WIDTH-1:0]  req_prime_count,
   input  logic [pss_pkg::START_WIDTH-1:0]  req_start_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pss_pkg::SUM_WIDTH-1:0]    rsp_prime_sum
);

   pss_pkg::pss_cmd_type    cmd;
   pss_pkg::pss_status_type status;

   pss_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pss_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .COUNT_MAX  (COUNT_MAX),
      .SUM_BITS   (SUM_BITS)
   ) u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .status          (status),
      .req_prime_count (req_prime_count),
      .req_start_value (req_start_value),
      .rsp_prime_sum   (rsp_prime_sum)
   );

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the prime sum search block
`timescale 1ns / 1ps

module testbench;

   // cost charged for one remainder per trial divisor
   localparam int DIV_CYCLES = 22;
   localparam int unsigned LONG_HOLD = 40000;
   localparam int unsigned MAX_GAP = 3000;
   localparam int RANDOM_ITEMS = 80;
   localparam longint unsigned SUM_LIMIT =
      (64'd1 << pss_pkg::SUM_BITS_DEFAULT) - 64'd1;
   localparam longint unsigned VALUE_MASK =
      (64'd1 << pss_pkg::VALUE_BITS_DEFAULT) - 64'd1;

   typedef struct {
      logic [pss_pkg::COUNT_WIDTH-1:0] prime_count;
      logic [pss_pkg::START_WIDTH-1:0] start_value;
      int unsigned                     gap;
      bit                              drain_first;
   } sum_request_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [pss_pkg::COUNT_WIDTH-1:0] req_prime_count = '0;
   logic [pss_pkg::START_WIDTH-1:0] req_start_value = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [pss_pkg::SUM_WIDTH-1:0]   rsp_prime_sum;

   sum_request_type                 requests_to_send[$];
   logic [pss_pkg::SUM_WIDTH-1:0]   sums_due[$];
   logic                            req_fire = 1'b0;
   int unsigned                     send_gap = 0;
   int unsigned                     stall_left = 0;
   bit                              hold_done = 1'b0;
   int unsigned                     sums_checked = 0;
   int unsigned                     error_count = 0;
   longint unsigned                 cycle_count = 0;
   longint unsigned                 cycle_limit = 64'd100_000_000;
   longint unsigned                 total_work = 0;

   // driver locals
   sum_request_type                 next_request;
   logic                            offer;
   // monitor locals
   logic [pss_pkg::SUM_WIDTH-1:0]   wanted_sum;
   longint unsigned                 unused_work;

   prime_sum_search dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_prime_count (req_prime_count),
      .req_start_value (req_start_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_prime_sum   (rsp_prime_sum)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // sum of the first count primes from start, plus a rough cycle cost
   function automatic logic [pss_pkg::SUM_WIDTH-1:0] prime_sum_of(
      input  logic [pss_pkg::COUNT_WIDTH-1:0] count,
      input  logic [pss_pkg::START_WIDTH-1:0] start,
      output longint unsigned                 work
   );
      longint unsigned wanted;
      longint unsigned found;
      longint unsigned cand;
      longint unsigned sum;
      longint unsigned divisor;
      bit              composite;
      wanted = (count > pss_pkg::COUNT_MAX_DEFAULT) ? pss_pkg::COUNT_MAX_DEFAULT : count;
      cand = start & VALUE_MASK;
      found = 0;
      sum = 0;
      work = 0;
      while (found < wanted) begin
         composite = (cand < pss_pkg::FIRST_PRIME);
         work += 2;
         for (divisor = pss_pkg::FIRST_PRIME; !composite && divisor * divisor <= cand;
              divisor++) begin
            work += DIV_CYCLES;
            if (cand % divisor == 0)
               composite = 1'b1;
         end
         if (!composite) begin
            sum = (sum > SUM_LIMIT - cand) ? SUM_LIMIT : sum + cand;
            found++;
         end
         cand++;
      end
      return sum[pss_pkg::SUM_WIDTH-1:0];
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 40);
      return $urandom_range(500, MAX_GAP);
   endfunction

   task automatic queue_request(input int unsigned count, input int unsigned start,
                                input int unsigned gap, input bit drain);
      sum_request_type item;
      longint unsigned work;
      item.prime_count = pss_pkg::COUNT_WIDTH'(count);
      item.start_value = pss_pkg::START_WIDTH'(start);
      item.gap = gap;
      item.drain_first = drain;
      void'(prime_sum_of(item.prime_count, item.start_value, work));
      total_work += work;
      requests_to_send.push_back(item);
   endtask

   task automatic note_mismatch(input string what,
                                input logic [pss_pkg::SUM_WIDTH-1:0] expected,
                                input logic [pss_pkg::SUM_WIDTH-1:0] actual);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, expected, actual);
   endtask

   // sender: holds each beat until taken, then waits its gap
   always @(negedge clock) begin
      offer = req_valid && !req_fire;
      if (!reset && !offer) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (requests_to_send.size() > 0 &&
                      !(requests_to_send[0].drain_first && sums_due.size() > 0)) begin
            next_request = requests_to_send.pop_front();
            req_prime_count <= next_request.prime_count;
            req_start_value <= next_request.start_value;
            send_gap = next_request.gap;
            offer = 1'b1;
         end
      end
      req_valid <= offer;
   end

   // receiver: random stalls, quiet windows, and one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && sums_checked == 3) begin
         hold_done = 1'b1;
         stall_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ((cycle_count % 60000) >= 15000 && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (sums_due.size() == 0) begin
               note_mismatch("prime_sum beat with none outstanding", '0, rsp_prime_sum);
            end else begin
               wanted_sum = sums_due.pop_front();
               if (rsp_prime_sum !== wanted_sum)
                  note_mismatch("prime_sum", wanted_sum, rsp_prime_sum);
            end
            sums_checked++;
         end
         if (req_valid && req_ready)
            sums_due.push_back(prime_sum_of(req_prime_count, req_start_value, unused_work));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** prime_sum_search: FAILED **");
         $finish;
      end
   end

   initial begin
      int unsigned i;
      int unsigned pick;
      int unsigned gap;

      // zero count, starts below the first prime, composite start
      queue_request(0, 0, pick_gap(), 1'b0);
      queue_request(0, 65535, pick_gap(), 1'b0);
      queue_request(1, 0, pick_gap(), 1'b0);
      queue_request(1, 1, pick_gap(), 1'b0);
      queue_request(1, 2, 0, 1'b0);
      queue_request(1, 3, 0, 1'b0);
      queue_request(1, 4, 0, 1'b0);
      queue_request(5, 0, 0, 1'b0);
      queue_request(10, 1, pick_gap(), 1'b0);
      // squares (of primes, and 255 squared) sit right on the divisor bound
      queue_request(1, 9, pick_gap(), 1'b0);
      queue_request(1, 25, pick_gap(), 1'b0);
      queue_request(1, 49, pick_gap(), 1'b0);
      queue_request(1, 65025, pick_gap(), 1'b0);
      // top of the start range (search runs past 16 bits) and other start values
      queue_request(1, 65535, pick_gap(), 1'b0);
      queue_request(3, 65521, pick_gap(), 1'b0);
      queue_request(2, 65530, pick_gap(), 1'b0);
      queue_request(4, 32768, pick_gap(), 1'b0);
      queue_request(1, 16'haaaa, pick_gap(), 1'b0);
      queue_request(1, 16'h5555, pick_gap(), 1'b0);
      queue_request(3, 1000, pick_gap(), 1'b0);
      // count above the maximum is clamped; sender drains first
      queue_request(2047, 0, pick_gap(), 1'b1);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 9);
         gap = ((i / 10) % 4 == 0) ? 0 : pick_gap();
         if (pick < 6)
            queue_request($urandom_range(0, 8), $urandom_range(0, 2047), gap,
                          $urandom_range(0, 19) == 0);
         else if (pick < 9)
            queue_request($urandom_range(0, 3), $urandom_range(0, 65535), gap,
                          $urandom_range(0, 19) == 0);
         else
            queue_request($urandom_range(16, 64), $urandom_range(0, 255), gap,
                          $urandom_range(0, 19) == 0);
      end

      cycle_limit = 4 * (total_work + requests_to_send.size() * (2 * MAX_GAP + 50)
                    + LONG_HOLD) + 100000;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (requests_to_send.size() > 0 || req_valid || sums_due.size() > 0)
         @(posedge clock);
      // catch any stray beat after the last one
      repeat (500) @(posedge clock);

      if (error_count == 0 && sums_due.size() == 0)
         $display("** prime_sum_search: PASSED **");
      else
         $display("** prime_sum_search: FAILED **");
      $finish;
   end

endmodule
